### rtl/csw_pkg.sv
// shared constants, register codes and helpers for the slip wall velocity block
`timescale 1ns / 1ps

package csw_pkg;

	localparam int PACK_W     = 63;
	localparam int CFG_DATA_W = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int TERM_W     = 26;
	localparam logic [TERM_W-1:0] TERM_MAX = '1;

	localparam int LIM_SHIFT   = 16;
	localparam int S_SHIFT     = 28;
	localparam int WALL_SHIFT  = 16;
	localparam int TRANS_SHIFT = 4;
	// 2^44 scaling of the slip term minus the quotient bits kept
	localparam int TSAT_SHIFT  = 44 - TERM_W;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_OMEGA_X  = 3'd0,
		REG_OMEGA_Y  = 3'd1,
		REG_OMEGA_Z  = 3'd2,
		REG_FRICTION = 3'd3,
		REG_MOTION   = 3'd4
	} csw_reg_t;

	localparam logic MOTION_ROT   = 1'b0;
	localparam logic MOTION_TRANS = 1'b1;

	typedef struct packed {
		logic signed [31:0] omega_x;
		logic signed [31:0] omega_y;
		logic signed [31:0] omega_z;
		logic [23:0]        friction_coefficient;
		logic               motion_kind;
	} csw_cfg_t;

	// clamp to the signed range of w bits
	function automatic logic signed [63:0] sat_signed(input logic signed [63:0] v,
			input int unsigned w);
		logic signed [63:0] hi;
		logic signed [63:0] lo;
		hi = (64'sd1 <<< (w - 1)) - 64'sd1;
		lo = -hi - 64'sd1;
		if (v > hi)
			return hi;
		if (v < lo)
			return lo;
		return v;
	endfunction

endpackage

### rtl/csw_if.sv
// face and result channel interfaces
`timescale 1ns / 1ps

interface csw_face_if import csw_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [31:0]       viscosity;
	logic [31:0]       pressure;
	logic [PACK_W-1:0] normal_vec;
	logic [PACK_W-1:0] grad_row_x;
	logic [PACK_W-1:0] grad_row_y;
	logic [PACK_W-1:0] grad_row_z;
	logic [PACK_W-1:0] cell_velocity;
	logic [31:0]       inverse_distance;
	logic [PACK_W-1:0] face_centre;

	modport source (output valid, viscosity, pressure, normal_vec, grad_row_x, grad_row_y,
		grad_row_z, cell_velocity, inverse_distance, face_centre, input ready);
	modport sink (input valid, viscosity, pressure, normal_vec, grad_row_x, grad_row_y,
		grad_row_z, cell_velocity, inverse_distance, face_centre, output ready);
endinterface

interface csw_result_if import csw_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [PACK_W-1:0] face_velocity;
	logic              slipping;

	modport source (output valid, face_velocity, slipping, input ready);
	modport sink (input valid, face_velocity, slipping, output ready);
endinterface

### rtl/csw_front.sv
// front pipeline: shear, friction limit, tangential velocity and wall velocity
`timescale 1ns / 1ps

module csw_front import csw_pkg::*; #(
	parameter int W = 21
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_valid,
	input  logic [31:0]           viscosity,
	input  logic [31:0]           pressure,
	input  logic [PACK_W-1:0]     normal_vec,
	input  logic [PACK_W-1:0]     grad_row_x,
	input  logic [PACK_W-1:0]     grad_row_y,
	input  logic [PACK_W-1:0]     grad_row_z,
	input  logic [PACK_W-1:0]     cell_velocity,
	input  logic [31:0]           inverse_distance,
	input  logic [PACK_W-1:0]     face_centre,
	input  csw_cfg_t              cfg,
	output logic                  out_valid,
	output logic                  slip,
	output logic                  tsat,
	output logic [31:0]           lim,
	output logic [63:0]           qden,
	output logic [2*W+15:0]       tsq,
	output logic [3*(W+7)-1:0]    ut_pk,
	output logic [3*W-1:0]        wall
);

	localparam int FRAC  = W - 2;
	localparam int UT_W  = W + 7;
	localparam int A_W   = W + 5;
	localparam int DOT_W = W + 4;
	localparam int S_W   = W + 10;
	localparam int SP_W  = W + 38;
	localparam int DN_W  = 2 * W + 4;
	localparam int SS_W  = 2 * S_W;
	localparam int TS_W  = 2 * UT_W;
	localparam int SQ_W  = SS_W + 2;
	localparam int TSQ_W = TS_W + 2;
	localparam int CR_W  = W + 32;

	logic signed [W-1:0] n_c [3];
	logic signed [W-1:0] u_c [3];
	logic signed [W-1:0] c_c [3];
	logic signed [W-1:0] g_c [3][3];
	logic signed [W:0]   t_c [3][3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			n_c[i]    = $signed(normal_vec[i*W +: W]);
			u_c[i]    = $signed(cell_velocity[i*W +: W]);
			c_c[i]    = $signed(face_centre[i*W +: W]);
			g_c[0][i] = $signed(grad_row_x[i*W +: W]);
			g_c[1][i] = $signed(grad_row_y[i*W +: W]);
			g_c[2][i] = $signed(grad_row_z[i*W +: W]);
		end
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				t_c[i][j] = (W+1)'(g_c[i][j]) + (W+1)'(g_c[j][i]);
	end

	// stage 1: products
	logic                   v_s1;
	logic signed [2*W:0]    p_s1 [3][3];
	logic signed [2*W-1:0]  du_s1 [3];
	logic [55:0]            pl_s1;
	logic [63:0]            q_s1;
	logic signed [CR_W-1:0] cr_s1 [6];
	logic [31:0]            mu_s1;
	logic signed [W-1:0]    n_s1 [3];
	logic signed [W-1:0]    u_s1 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++)
					p_s1[i][j] <= t_c[i][j] * n_c[j];
				du_s1[i] <= u_c[i] * n_c[i];
				n_s1[i]  <= n_c[i];
				u_s1[i]  <= u_c[i];
			end
			pl_s1    <= pressure * cfg.friction_coefficient;
			q_s1     <= viscosity * inverse_distance;
			cr_s1[0] <= cfg.omega_y * c_c[2];
			cr_s1[1] <= cfg.omega_z * c_c[1];
			cr_s1[2] <= cfg.omega_z * c_c[0];
			cr_s1[3] <= cfg.omega_x * c_c[2];
			cr_s1[4] <= cfg.omega_x * c_c[1];
			cr_s1[5] <= cfg.omega_y * c_c[0];
			mu_s1    <= viscosity;
		end
	end

	// stage 2: sums, limit and wall velocity
	logic signed [2*W+2:0]  acc_c [3];
	logic signed [2*W+1:0]  dsum_c;
	logic signed [CR_W:0]   cd_c [3];
	logic [3*W-1:0]         wall_c;
	logic signed [63:0]     trans_c [3];

	always_comb begin
		dsum_c = '0;
		for (int i = 0; i < 3; i++) begin
			acc_c[i] = '0;
			for (int j = 0; j < 3; j++)
				acc_c[i] = acc_c[i] + (2*W+3)'(p_s1[i][j]);
			dsum_c = dsum_c + (2*W+2)'(du_s1[i]);
		end
		cd_c[0] = (CR_W+1)'(cr_s1[0]) - (CR_W+1)'(cr_s1[1]);
		cd_c[1] = (CR_W+1)'(cr_s1[2]) - (CR_W+1)'(cr_s1[3]);
		cd_c[2] = (CR_W+1)'(cr_s1[4]) - (CR_W+1)'(cr_s1[5]);
		trans_c[0] = 64'(cfg.omega_x) >>> TRANS_SHIFT;
		trans_c[1] = 64'(cfg.omega_y) >>> TRANS_SHIFT;
		trans_c[2] = 64'(cfg.omega_z) >>> TRANS_SHIFT;
		for (int i = 0; i < 3; i++) begin
			if (cfg.motion_kind == MOTION_ROT)
				wall_c[i*W +: W] = W'(sat_signed(
					64'($signed(cd_c[i][CR_W:WALL_SHIFT])), W));
			else
				wall_c[i*W +: W] = W'(sat_signed(trans_c[i], W));
		end
	end

	logic                    v_s2;
	logic signed [A_W-1:0]   a_s2 [3];
	logic signed [DOT_W-1:0] dot_s2;
	logic [39:0]             lim_s2;
	logic [63:0]             q_s2;
	logic [31:0]             mu_s2;
	logic signed [W-1:0]     n_s2 [3];
	logic signed [W-1:0]     u_s2 [3];
	logic [3*W-1:0]          wall_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				a_s2[i] <= $signed(acc_c[i][2*W+2:FRAC]);
				n_s2[i] <= n_s1[i];
				u_s2[i] <= u_s1[i];
			end
			dot_s2  <= $signed(dsum_c[2*W+1:FRAC]);
			lim_s2  <= pl_s1[55:LIM_SHIFT];
			q_s2    <= q_s1;
			mu_s2   <= mu_s1;
			wall_s2 <= wall_c;
		end
	end

	// stage 3: viscosity scaling, normal projection, limit square
	logic                   v_s3;
	logic signed [SP_W-1:0] sp_s3 [3];
	logic signed [DN_W-1:0] dn_s3 [3];
	logic [63:0]            limsq_s3;
	logic                   limok_s3;
	logic                   tsat_s3;
	logic [31:0]            lim_s3;
	logic [63:0]            q_s3;
	logic signed [W-1:0]    u_s3 [3];
	logic [3*W-1:0]         wall_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sp_s3[i] <= $signed({1'b0, mu_s2}) * a_s2[i];
				dn_s3[i] <= dot_s2 * n_s2[i];
				u_s3[i]  <= u_s2[i];
			end
			limsq_s3 <= lim_s2[31:0] * lim_s2[31:0];
			limok_s3 <= (lim_s2[39:32] == '0);
			// quotient would not fit the slip term
			tsat_s3  <= ((64'(lim_s2[31:0]) << TSAT_SHIFT) >= q_s2);
			lim_s3   <= lim_s2[31:0];
			q_s3     <= q_s2;
			wall_s3  <= wall_s2;
		end
	end

	// stage 4: shear and tangential components
	logic                   v_s4;
	logic signed [S_W-1:0]  s_s4 [3];
	logic signed [UT_W-1:0] ut_s4 [3];
	logic [63:0]            limsq_s4;
	logic                   limok_s4;
	logic                   tsat_s4;
	logic [31:0]            lim_s4;
	logic [63:0]            q_s4;
	logic [3*W-1:0]         wall_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				s_s4[i]  <= $signed(sp_s3[i][SP_W-1:S_SHIFT]);
				ut_s4[i] <= UT_W'(u_s3[i]) - UT_W'($signed(dn_s3[i][DN_W-1:FRAC]));
			end
			limsq_s4 <= limsq_s3;
			limok_s4 <= limok_s3;
			tsat_s4  <= tsat_s3;
			lim_s4   <= lim_s3;
			q_s4     <= q_s3;
			wall_s4  <= wall_s3;
		end
	end

	// stage 5: squares
	logic                   v_s5;
	logic signed [SS_W-1:0] ss_s5 [3];
	logic signed [TS_W-1:0] ts_s5 [3];
	logic signed [UT_W-1:0] ut_s5 [3];
	logic [63:0]            limsq_s5;
	logic                   limok_s5;
	logic                   tsat_s5;
	logic [31:0]            lim_s5;
	logic [63:0]            q_s5;
	logic [3*W-1:0]         wall_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				ss_s5[i] <= s_s4[i] * s_s4[i];
				ts_s5[i] <= ut_s4[i] * ut_s4[i];
				ut_s5[i] <= ut_s4[i];
			end
			limsq_s5 <= limsq_s4;
			limok_s5 <= limok_s4;
			tsat_s5  <= tsat_s4;
			lim_s5   <= lim_s4;
			q_s5     <= q_s4;
			wall_s5  <= wall_s4;
		end
	end

	// stage 6: squared magnitudes and slip decision
	logic [SQ_W-1:0]  sumsq_c;
	logic [TSQ_W-1:0] tsum_c;

	always_comb begin
		sumsq_c = '0;
		tsum_c  = '0;
		for (int i = 0; i < 3; i++) begin
			sumsq_c = sumsq_c + SQ_W'($unsigned(ss_s5[i]));
			tsum_c  = tsum_c + TSQ_W'($unsigned(ts_s5[i]));
		end
	end

	logic                v_s6;
	logic                slip_s6;
	logic                tsat_s6;
	logic [31:0]         lim_s6;
	logic [63:0]         q_s6;
	logic [TSQ_W-1:0]    tsq_s6;
	logic [3*UT_W-1:0]   ut_s6;
	logic [3*W-1:0]      wall_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			slip_s6 <= limok_s5 && (64'(sumsq_c) > limsq_s5);
			tsat_s6 <= tsat_s5;
			lim_s6  <= lim_s5;
			q_s6    <= q_s5;
			tsq_s6  <= tsum_c;
			for (int i = 0; i < 3; i++)
				ut_s6[i*UT_W +: UT_W] <= ut_s5[i];
			wall_s6 <= wall_s5;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	assign out_valid = v_s6;
	assign slip      = slip_s6;
	assign tsat      = tsat_s6;
	assign lim       = lim_s6;
	assign qden      = q_s6;
	assign tsq       = tsq_s6;
	assign ut_pk     = ut_s6;
	assign wall      = wall_s6;

endmodule

### rtl/csw_sqrt_pipe.sv
// pipelined restoring integer square root, one root bit per stage
`timescale 1ns / 1ps

module csw_sqrt_pipe #(
	parameter int X_W    = 58,
	parameter int SIDE_W = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  logic [X_W-1:0]     x,
	input  logic [SIDE_W-1:0]  side_in,
	output logic               out_valid,
	output logic [X_W/2-1:0]   root,
	output logic [SIDE_W-1:0]  side_out
);

	localparam int R_W   = X_W / 2;
	localparam int REM_W = R_W + 1;

	logic               v_s    [R_W];
	logic [X_W-1:0]     x_s    [R_W];
	logic [REM_W-1:0]   rem_s  [R_W];
	logic [R_W-1:0]     root_s [R_W];
	logic [SIDE_W-1:0]  side_s [R_W];

	for (genvar k = 0; k < R_W; k++) begin : g_st
		logic               vp;
		logic [X_W-1:0]     xp;
		logic [REM_W-1:0]   rp;
		logic [R_W-1:0]     qp;
		logic [SIDE_W-1:0]  sp;
		logic [REM_W+1:0]   sh;
		logic [REM_W+1:0]   tr;
		logic               ge;

		if (k == 0) begin : g_first
			assign vp = in_valid;
			assign xp = x;
			assign rp = '0;
			assign qp = '0;
			assign sp = side_in;
		end else begin : g_next
			assign vp = v_s[k-1];
			assign xp = x_s[k-1];
			assign rp = rem_s[k-1];
			assign qp = root_s[k-1];
			assign sp = side_s[k-1];
		end

		assign sh = {rp, xp[X_W-1 -: 2]};
		assign tr = (REM_W+2)'({qp, 2'b01});
		assign ge = (sh >= tr);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_s[k] <= 1'b0;
			else if (en)
				v_s[k] <= vp;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_s[k]    <= xp << 2;
				rem_s[k]  <= REM_W'(ge ? sh - tr : sh);
				root_s[k] <= {qp[R_W-2:0], ge};
				side_s[k] <= sp;
			end
		end
	end

	assign out_valid = v_s[R_W-1];
	assign root      = root_s[R_W-1];
	assign side_out  = side_s[R_W-1];

endmodule

### rtl/csw_div_pipe.sv
// pipelined restoring divider with a shared divisor, one quotient bit per stage
`timescale 1ns / 1ps

module csw_div_pipe #(
	parameter int DEN_W  = 64,
	parameter int Q_W    = 26,
	parameter int LANES  = 1,
	parameter int SIDE_W = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  logic [DEN_W-1:0]   den,
	input  logic [DEN_W-1:0]   rem0 [LANES],
	input  logic [Q_W-1:0]     low [LANES],
	input  logic [SIDE_W-1:0]  side_in,
	output logic               out_valid,
	output logic [Q_W-1:0]     quo [LANES],
	output logic [SIDE_W-1:0]  side_out
);

	// the partial remainder entering each lane must already be below den

	logic               v_s    [Q_W];
	logic [DEN_W-1:0]   den_s  [Q_W];
	logic [DEN_W-1:0]   rem_s  [Q_W][LANES];
	logic [Q_W-1:0]     low_s  [Q_W][LANES];
	logic [Q_W-1:0]     quo_s  [Q_W][LANES];
	logic [SIDE_W-1:0]  side_s [Q_W];

	for (genvar k = 0; k < Q_W; k++) begin : g_st
		logic               vp;
		logic [DEN_W-1:0]   dp;
		logic [DEN_W-1:0]   rp [LANES];
		logic [Q_W-1:0]     lp [LANES];
		logic [Q_W-1:0]     qp [LANES];
		logic [SIDE_W-1:0]  sp;
		logic [DEN_W:0]     trial [LANES];
		logic               ge [LANES];

		if (k == 0) begin : g_first
			assign vp = in_valid;
			assign dp = den;
			assign sp = side_in;
			for (genvar l = 0; l < LANES; l++) begin : g_ln
				assign rp[l] = rem0[l];
				assign lp[l] = low[l];
				assign qp[l] = '0;
			end
		end else begin : g_next
			assign vp = v_s[k-1];
			assign dp = den_s[k-1];
			assign sp = side_s[k-1];
			for (genvar l = 0; l < LANES; l++) begin : g_ln
				assign rp[l] = rem_s[k-1][l];
				assign lp[l] = low_s[k-1][l];
				assign qp[l] = quo_s[k-1][l];
			end
		end

		always_comb begin
			for (int l = 0; l < LANES; l++) begin
				trial[l] = {rp[l], lp[l][Q_W-1]};
				ge[l]    = (trial[l] >= {1'b0, dp});
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_s[k] <= 1'b0;
			else if (en)
				v_s[k] <= vp;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				den_s[k]  <= dp;
				side_s[k] <= sp;
				for (int l = 0; l < LANES; l++) begin
					rem_s[k][l] <= DEN_W'(ge[l] ? trial[l] - {1'b0, dp} : trial[l]);
					low_s[k][l] <= lp[l] << 1;
					quo_s[k][l] <= {qp[l][Q_W-2:0], ge[l]};
				end
			end
		end
	end

	always_comb begin
		for (int l = 0; l < LANES; l++)
			quo[l] = quo_s[Q_W-1][l];
	end

	assign out_valid = v_s[Q_W-1];
	assign side_out  = side_s[Q_W-1];

endmodule

### rtl/csw_out.sv
// result select, saturation, output register and skid word
`timescale 1ns / 1ps

module csw_out import csw_pkg::*; #(
	parameter int W = 21
) (
	input  logic                  clk,
	input  logic                  arst_n,
	output logic                  en,
	input  logic                  in_valid,
	input  logic                  slip,
	input  logic                  mzero,
	input  logic [3*(W+7)-1:0]    ut_pk,
	input  logic [TERM_W-1:0]     quo [3],
	input  logic [3*W-1:0]        wall,
	csw_result_if.source          result
);

	localparam int UT_W = W + 7;

	logic signed [UT_W-1:0] ut_c [3];
	logic signed [63:0]     diff_c [3];
	logic [3*W-1:0]         res_c;
	logic [PACK_W-1:0]      vel_c;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ut_c[i]   = $signed(ut_pk[i*UT_W +: UT_W]);
			// quotient takes the sign of the tangential component
			diff_c[i] = 64'(ut_c[i]) - ((ut_c[i] < 0) ? -$signed(64'(quo[i]))
				: $signed(64'(quo[i])));
			if (!slip)
				res_c[i*W +: W] = wall[i*W +: W];
			else if (mzero)
				res_c[i*W +: W] = '0;
			else
				res_c[i*W +: W] = W'(sat_signed(diff_c[i], W));
		end
		vel_c = PACK_W'(res_c);
	end

	logic              ov_q;
	logic              sv_q;
	logic [PACK_W-1:0] ovel_q;
	logic [PACK_W-1:0] svel_q;
	logic              oslip_q;
	logic              sslip_q;
	logic              arr;

	assign en  = ~sv_q;
	assign arr = en & in_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
			sv_q <= 1'b0;
		end else if (ov_q && !result.ready) begin
			if (arr)
				sv_q <= 1'b1;
		end else begin
			ov_q <= sv_q | arr;
			sv_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ov_q && !result.ready) begin
			if (arr) begin
				svel_q  <= vel_c;
				sslip_q <= slip;
			end
		end else if (sv_q) begin
			ovel_q  <= svel_q;
			oslip_q <= sslip_q;
		end else if (arr) begin
			ovel_q  <= vel_c;
			oslip_q <= slip;
		end
	end

	assign result.valid         = ov_q;
	assign result.face_velocity = ovel_q;
	assign result.slipping      = oslip_q;

endmodule

### rtl/coulomb_slip_wall_velocity.sv
// top level of the Coulomb slip wall velocity pipeline
//
//  channel   | dir | handshake     | word
//  face      | in  | valid/ready   | viscosity .. face_centre, one wall face
//  result    | out | valid/ready   | face_velocity, slipping
//  cfg       | in  | cfg_wr_en     | cfg_index, cfg_data
//
// one face per cycle while face.ready is high. the path runs through six front stages,
// one stage per root bit in the square root, 26 stages for the slip term division,
// a scaling stage, 26 stages for the per-axis quotient and the output register.
// reset clears the valid bits and the config register; the data registers are not
// reset. a stalled result parks in a skid word while the pipeline moves on; once
// that fills, the whole pipeline holds and face.ready drops.
`timescale 1ns / 1ps

module coulomb_slip_wall_velocity import csw_pkg::*; #(
	parameter int COMPONENT_WIDTH = 21
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	csw_face_if.sink              face,
	csw_result_if.source          result
);

	localparam int W      = COMPONENT_WIDTH;
	localparam int UT_W   = W + 7;
	localparam int TSQ_W  = 2 * UT_W + 2;
	localparam int M_W    = TSQ_W / 2;
	localparam int D_W    = TERM_W + UT_W;
	localparam int SQ_SW  = 2 + 32 + 64 + 3 * W + 3 * UT_W;
	localparam int TD_SW  = 2 + M_W + 3 * W + 3 * UT_W;
	localparam int QD_SW  = 2 + 3 * W + 3 * UT_W;

	csw_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_OMEGA_X:  cfg_q.omega_x <= $signed(cfg_data);
				REG_OMEGA_Y:  cfg_q.omega_y <= $signed(cfg_data);
				REG_OMEGA_Z:  cfg_q.omega_z <= $signed(cfg_data);
				REG_FRICTION: cfg_q.friction_coefficient <= cfg_data[23:0];
				REG_MOTION:   cfg_q.motion_kind <= cfg_data[0];
				default: ;
			endcase
		end
	end

	logic en;
	assign face.ready = en;

	logic               f_valid, f_slip, f_tsat;
	logic [31:0]        f_lim;
	logic [63:0]        f_q;
	logic [TSQ_W-1:0]   f_tsq;
	logic [3*UT_W-1:0]  f_ut;
	logic [3*W-1:0]     f_wall;

	csw_front #(.W(W)) u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.en               (en),
		.in_valid         (face.valid),
		.viscosity        (face.viscosity),
		.pressure         (face.pressure),
		.normal_vec       (face.normal_vec),
		.grad_row_x       (face.grad_row_x),
		.grad_row_y       (face.grad_row_y),
		.grad_row_z       (face.grad_row_z),
		.cell_velocity    (face.cell_velocity),
		.inverse_distance (face.inverse_distance),
		.face_centre      (face.face_centre),
		.cfg              (cfg_q),
		.out_valid        (f_valid),
		.slip             (f_slip),
		.tsat             (f_tsat),
		.lim              (f_lim),
		.qden             (f_q),
		.tsq              (f_tsq),
		.ut_pk            (f_ut),
		.wall             (f_wall)
	);

	// tangential magnitude
	logic              sq_valid;
	logic [M_W-1:0]    sq_root;
	logic [SQ_SW-1:0]  sq_side;

	csw_sqrt_pipe #(.X_W(TSQ_W), .SIDE_W(SQ_SW)) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (f_valid),
		.x         (f_tsq),
		.side_in   ({f_slip, f_tsat, f_lim, f_q, f_wall, f_ut}),
		.out_valid (sq_valid),
		.root      (sq_root),
		.side_out  (sq_side)
	);

	logic [3*UT_W-1:0] sq_ut;
	logic [3*W-1:0]    sq_wall;
	logic [63:0]       sq_q;
	logic [31:0]       sq_lim;
	logic              sq_tsat, sq_slip;

	assign sq_ut   = sq_side[3*UT_W-1:0];
	assign sq_wall = sq_side[3*UT_W +: 3*W];
	assign sq_q    = sq_side[3*UT_W+3*W +: 64];
	assign sq_lim  = sq_side[3*UT_W+3*W+64 +: 32];
	assign sq_tsat = sq_side[SQ_SW-2];
	assign sq_slip = sq_side[SQ_SW-1];

	// slip term: limit * 2^44 / (viscosity * distance)
	logic [63:0]        td_rem0 [1];
	logic [TERM_W-1:0]  td_low [1];
	logic [TERM_W-1:0]  td_quo [1];
	logic               td_valid;
	logic [TD_SW-1:0]   td_side;

	assign td_rem0[0] = 64'(sq_lim) << TSAT_SHIFT;
	assign td_low[0]  = '0;

	csw_div_pipe #(.DEN_W(64), .Q_W(TERM_W), .LANES(1), .SIDE_W(TD_SW)) u_term_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (sq_valid),
		.den       (sq_q),
		.rem0      (td_rem0),
		.low       (td_low),
		.side_in   ({sq_slip, sq_tsat, sq_root, sq_wall, sq_ut}),
		.out_valid (td_valid),
		.quo       (td_quo),
		.side_out  (td_side)
	);

	logic [3*UT_W-1:0] td_ut;
	logic [3*W-1:0]    td_wall;
	logic [M_W-1:0]    td_m;
	logic              td_tsat, td_slip;
	logic [TERM_W-1:0] term_c;
	logic [UT_W-1:0]   mag_c [3];

	assign td_ut   = td_side[3*UT_W-1:0];
	assign td_wall = td_side[3*UT_W +: 3*W];
	assign td_m    = td_side[3*UT_W+3*W +: M_W];
	assign td_tsat = td_side[TD_SW-2];
	assign td_slip = td_side[TD_SW-1];
	assign term_c  = td_tsat ? TERM_MAX : td_quo[0];

	always_comb begin
		for (int i = 0; i < 3; i++)
			mag_c[i] = td_ut[i*UT_W + UT_W - 1] ? UT_W'(-td_ut[i*UT_W +: UT_W])
				: td_ut[i*UT_W +: UT_W];
	end

	// scaling stage: term * |ut|
	logic               v_s1;
	logic [D_W-1:0]     dvd_s1 [3];
	logic [M_W-1:0]     m_s1;
	logic               mzero_s1;
	logic               slip_s1;
	logic [3*UT_W-1:0]  ut_s1;
	logic [3*W-1:0]     wall_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (en)
			v_s1 <= td_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++)
				dvd_s1[i] <= term_c * mag_c[i];
			m_s1     <= td_m;
			mzero_s1 <= (td_m == '0);
			slip_s1  <= td_slip;
			ut_s1    <= td_ut;
			wall_s1  <= td_wall;
		end
	end

	// per-axis quotient term * |ut| / m, below 2^26 since |ut| <= m
	logic [M_W-1:0]     qd_rem0 [3];
	logic [TERM_W-1:0]  qd_low [3];
	logic [TERM_W-1:0]  qd_quo [3];
	logic               qd_valid;
	logic [QD_SW-1:0]   qd_side;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			qd_rem0[i] = M_W'(dvd_s1[i] >> TERM_W);
			qd_low[i]  = dvd_s1[i][TERM_W-1:0];
		end
	end

	csw_div_pipe #(.DEN_W(M_W), .Q_W(TERM_W), .LANES(3), .SIDE_W(QD_SW)) u_quo_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s1),
		.den       (m_s1),
		.rem0      (qd_rem0),
		.low       (qd_low),
		.side_in   ({slip_s1, mzero_s1, wall_s1, ut_s1}),
		.out_valid (qd_valid),
		.quo       (qd_quo),
		.side_out  (qd_side)
	);

	csw_out #(.W(W)) u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (qd_valid),
		.slip     (qd_side[QD_SW-1]),
		.mzero    (qd_side[QD_SW-2]),
		.ut_pk    (qd_side[3*UT_W-1:0]),
		.quo      (qd_quo),
		.wall     (qd_side[3*UT_W +: 3*W]),
		.result   (result)
	);

endmodule
